// ----- rtl/mrc_pkg.sv -----
package mrc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_ADDRESS  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_FUNCTION = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHECK_MODE        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_REGISTER_COUNT    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ECHO_WORD         = 3'd4;

    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [6:0]  FUNC_MASK   = 7'h7F;
    localparam logic [7:0]  ECHO_LENGTH = 8'd8;

    localparam logic MODE_READ = 1'b0;
    localparam logic MODE_ECHO = 1'b1;

    localparam logic KIND_WORD   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_PROTOCOL = 2'd1;
    localparam logic [1:0] STATUS_CRC      = 2'd2;

    typedef struct packed {
        logic [7:0]  expected_address;
        logic [6:0]  expected_function;
        logic        check_mode;
        logic [6:0]  register_count;
        logic [31:0] echo_word;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] register_word;
        logic [1:0]  status;
    } result_t;

endpackage

// ----- rtl/mrc_cfg_regs.sv -----
module mrc_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [mrc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mrc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output mrc_pkg::cfg_t                     cfg
);
    import mrc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.expected_address  <= 8'd1;
            cfg_reg.expected_function <= 7'd3;
            cfg_reg.check_mode        <= MODE_READ;
            cfg_reg.register_count    <= 7'd1;
            cfg_reg.echo_word         <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_EXPECTED_ADDRESS:  cfg_reg.expected_address  <= cfg_data[7:0];
                REG_EXPECTED_FUNCTION: cfg_reg.expected_function <= cfg_data[6:0];
                REG_CHECK_MODE:        cfg_reg.check_mode        <= cfg_data[0];
                REG_REGISTER_COUNT:    cfg_reg.register_count    <= cfg_data[6:0];
                REG_ECHO_WORD:         cfg_reg.echo_word         <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/mrc_crc8.sv -----
module mrc_crc8 (
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [15:0] crc_out
);
    import mrc_pkg::*;

    always_comb begin
        logic [15:0] c;
        c = crc_in ^ {8'h00, data_in};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

// ----- rtl/mrc_frame.sv -----
module mrc_frame #(
    parameter int MAX_REGISTERS = 125
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [7:0]        rx_byte,
    input  mrc_pkg::cfg_t     cfg,
    output logic              res_valid,
    output mrc_pkg::result_t  res
);
    import mrc_pkg::*;

    localparam logic [6:0] MAX_COUNT = 7'(MAX_REGISTERS);

    logic [7:0]  pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next;
    logic        hdr_bad_reg, hdr_bad_next;
    logic        body_bad_reg, body_bad_next;
    logic [7:0]  high_reg, high_next;
    logic [7:0]  crc_low_reg, crc_low_next;

    logic [15:0] crc_fed;
    logic [6:0]  count;
    logic [7:0]  total_len;
    logic [8:0]  pos_plus1;
    logic [8:0]  pos_plus2;
    logic        last_byte;
    logic        crc_low_byte;
    logic [7:0]  echo_want;

    mrc_crc8 u_crc8 (
        .crc_in  (crc_reg),
        .data_in (rx_byte),
        .crc_out (crc_fed)
    );

    always_comb begin
        if (cfg.register_count == 7'd0) begin
            count = 7'd1;
        end else if (cfg.register_count > MAX_COUNT) begin
            count = MAX_COUNT;
        end else begin
            count = cfg.register_count;
        end
        total_len = (cfg.check_mode == MODE_ECHO) ? ECHO_LENGTH
                                                  : 8'd5 + {count, 1'b0};
        pos_plus1    = {1'b0, pos_reg} + 9'd1;
        pos_plus2    = {1'b0, pos_reg} + 9'd2;
        last_byte    = pos_plus1 >= {1'b0, total_len};
        crc_low_byte = pos_plus2 == {1'b0, total_len};
    end

    // byte 2 is the most significant echo byte
    always_comb begin
        unique case (pos_reg[2:0])
            3'd2:    echo_want = cfg.echo_word[31:24];
            3'd3:    echo_want = cfg.echo_word[23:16];
            3'd4:    echo_want = cfg.echo_word[15:8];
            3'd5:    echo_want = cfg.echo_word[7:0];
            default: echo_want = 8'h00;
        endcase
    end

    always_comb begin
        pos_next      = pos_reg;
        crc_next      = crc_reg;
        hdr_bad_next  = hdr_bad_reg;
        body_bad_next = body_bad_reg;
        high_next     = high_reg;
        crc_low_next  = crc_low_reg;
        res_valid     = 1'b0;
        res.kind          = KIND_WORD;
        res.register_word = 16'h0000;
        res.status        = STATUS_OK;

        if (accept) begin
            if (last_byte) begin
                res_valid  = 1'b1;
                res.kind   = KIND_STATUS;
                // header error wins over crc error
                if (hdr_bad_reg) begin
                    res.status = STATUS_PROTOCOL;
                end else if ({rx_byte, crc_low_reg} != crc_reg) begin
                    res.status = STATUS_CRC;
                end else if (body_bad_reg) begin
                    res.status = STATUS_PROTOCOL;
                end else begin
                    res.status = STATUS_OK;
                end
                pos_next      = 8'd0;
                crc_next      = CRC_INIT;
                hdr_bad_next  = 1'b0;
                body_bad_next = 1'b0;
                high_next     = 8'd0;
                crc_low_next  = 8'd0;
            end else begin
                pos_next = pos_plus1[7:0];
                if (crc_low_byte) begin
                    crc_low_next = rx_byte;
                end else begin
                    crc_next = crc_fed;
                    if (pos_reg == 8'd0) begin
                        if (rx_byte != cfg.expected_address) hdr_bad_next = 1'b1;
                    end else if (pos_reg == 8'd1) begin
                        if ((rx_byte[6:0] & FUNC_MASK) != cfg.expected_function) begin
                            hdr_bad_next = 1'b1;
                        end
                    end else if (cfg.check_mode == MODE_ECHO) begin
                        if (pos_reg <= 8'd5 && rx_byte != echo_want) body_bad_next = 1'b1;
                    end else if (pos_reg == 8'd2) begin
                        if (rx_byte != {count, 1'b0}) body_bad_next = 1'b1;
                    end else if (pos_reg[0]) begin
                        high_next = rx_byte;
                    end else begin
                        res_valid         = 1'b1;
                        res.kind          = KIND_WORD;
                        res.register_word = {high_reg, rx_byte};
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= 8'd0;
            crc_reg      <= CRC_INIT;
            hdr_bad_reg  <= 1'b0;
            body_bad_reg <= 1'b0;
            high_reg     <= 8'd0;
            crc_low_reg  <= 8'd0;
        end else begin
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            hdr_bad_reg  <= hdr_bad_next;
            body_bad_reg <= body_bad_next;
            high_reg     <= high_next;
            crc_low_reg  <= crc_low_next;
        end
    end

endmodule

// ----- rtl/modbus_rtu_response_checker.sv -----
// a byte accepted on the input that completes a result shows it at m_valid in the next cycle
// throughput: one received byte per cycle unless stalled; crc update and checks finish in that cycle
// input stalls only while a result waits with m_ready low; it frees as it is taken
// reset (aresetn low, synchronous): config returns to defaults, frame state restarts
// at byte 0 with the crc seeded, and any pending result is dropped
module modbus_rtu_response_checker #(
    parameter int MAX_REGISTERS = 125
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [mrc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mrc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_rx_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_kind,
    output logic [15:0]                       m_register_word,
    output logic [1:0]                        m_status
);
    import mrc_pkg::*;

    cfg_t    cfg;
    logic    accept;
    logic    res_valid;
    result_t res;

    logic    out_valid_reg;
    result_t out_reg;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    mrc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mrc_frame #(
        .MAX_REGISTERS (MAX_REGISTERS)
    ) u_frame (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .rx_byte   (s_rx_byte),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_kind          = out_reg.kind;
    assign m_register_word = out_reg.register_word;
    assign m_status        = out_reg.status;

endmodule
